FILE: rtl/core/tg_pkg.sv
// tg_pkg: shared types and constants for the multichannel tone generator
// holds the op codes, the queued command and the divider handshake structs
// no dependencies
package tg_pkg;

   localparam int COUNT_W     = 16;
   localparam int HALF_W      = 15;
   localparam int BUDGET_W    = 22;
   localparam int CHANNEL_W   = 3;
   localparam int FREQ_W      = 16;
   localparam int MASK_W      = 8;
   localparam int DIVIDEND_W  = 32;
   localparam int DIVISOR_W   = 16;
   localparam int QUEUE_DEPTH = 2;
   localparam int RECIP_W     = 29;
   localparam int RECIP_SHIFT = 38;

   localparam logic [FREQ_W-1:0]    FREQ_MIN      = 16'd20;
   localparam logic [FREQ_W-1:0]    FREQ_MAX      = 16'd20000;
   localparam logic [DIVISOR_W-1:0] MS_PER_SECOND = 16'd1000;
   localparam logic [HALF_W-1:0]    HALF_MAX      = 15'h7FFF;
   // floor(x / 1000) = (x * MS_RECIP) >> RECIP_SHIFT for any 32-bit x
   localparam logic [RECIP_W-1:0]   MS_RECIP      = 29'd274877907;

   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_START = 2'd1,
      OP_STOP  = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      FR_IDLE,
      FR_HALF,
      FR_BUDGET,
      FR_PUSH
   } front_state_type;

   typedef struct packed {
      op_type                op;
      logic [CHANNEL_W-1:0]  channel;
      logic [HALF_W-1:0]     half;
      logic [BUDGET_W-1:0]   budget;
      logic                  endless;
   } cmd_type;

   typedef struct packed {
      logic                  start;
      logic [DIVIDEND_W-1:0] dividend;
      logic [DIVISOR_W-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic                  busy;
      logic                  done;
      logic [DIVIDEND_W-1:0] quotient;
   } div_rsp_type;

endpackage

FILE: rtl/core/tg_div.sv
// tg_div: radix-2 restoring divider, one quotient bit per cycle
// depends on tg_pkg
module tg_div (
   input  logic                clock,
   input  logic                reset,
   input  tg_pkg::div_req_type div_req,
   output tg_pkg::div_rsp_type div_rsp
);
   import tg_pkg::*;

   localparam int STEP_W = $clog2(DIVIDEND_W);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  divisor_ff, divisor_in;

   always_comb begin
      logic [DIVISOR_W:0] rem_shift;
      logic               ge;
      rem_shift  = {rem_ff, quo_ff[DIVIDEND_W-1]};
      ge         = rem_shift >= {1'b0, divisor_ff};
      busy_in    = busy_ff;
      done_in    = 1'b0;
      step_in    = step_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      divisor_in = divisor_ff;
      if (div_req.start) begin
         busy_in    = 1'b1;
         step_in    = '0;
         rem_in     = '0;
         quo_in     = div_req.dividend;
         divisor_in = div_req.divisor;
      end else if (busy_ff) begin
         rem_in  = ge ? DIVISOR_W'(rem_shift - {1'b0, divisor_ff}) : rem_shift[DIVISOR_W-1:0];
         quo_in  = {quo_ff[DIVIDEND_W-2:0], ge};
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(DIVIDEND_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff    <= step_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      divisor_ff <= divisor_in;
   end

   assign div_rsp.busy     = busy_ff;
   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

`ifndef SYNTHESIS
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !busy_ff)
      else $error("divider restarted while busy");
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff))
      else $error("divider done without a running division");
`endif

endmodule

FILE: rtl/core/tg_front.sv
// tg_front: accepts request beats, checks them and works out half period and budget
// depends on tg_pkg and tg_div
module tg_front #(
   parameter int CHANNELS         = 8,
   parameter int TICKS_PER_SECOND = 1000000
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_op,
   input  logic [2:0]          req_channel,
   input  logic [15:0]         req_frequency_hz,
   input  logic [15:0]         req_duration_ms,
   output logic                push,
   output tg_pkg::cmd_type     push_data,
   input  logic                full
);
   import tg_pkg::*;

   front_state_type       state_ff, state_in;
   cmd_type               cmd_ff, cmd_in;
   logic [FREQ_W-1:0]     freq_ff, freq_in;
   logic [FREQ_W-1:0]     dur_ff, dur_in;
   logic [DIVIDEND_W-1:0] prod_ff, prod_in;
   div_req_type           div_req;
   div_rsp_type           div_rsp;

   tg_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   always_comb begin
      logic    ch_ok;
      logic    freq_ok;
      op_type  op;
      cmd_type imm_cmd;
      logic [DIVIDEND_W+RECIP_W-1:0] scaled;
      op       = op_type'(req_op);
      ch_ok    = {29'd0, req_channel} < 32'(CHANNELS);
      freq_ok  = (req_frequency_hz >= FREQ_MIN) && (req_frequency_hz <= FREQ_MAX);
      scaled   = prod_ff * MS_RECIP;
      imm_cmd         = '0;
      imm_cmd.op      = op;
      imm_cmd.channel = req_channel;
      if (op == OP_START || (op == OP_STOP && !ch_ok)) begin
         imm_cmd.op = OP_NONE;
      end
      state_in  = state_ff;
      cmd_in    = cmd_ff;
      freq_in   = freq_ff;
      dur_in    = dur_ff;
      prod_in   = prod_ff;
      req_ready = 1'b0;
      push      = 1'b0;
      push_data = imm_cmd;
      div_req   = '0;
      case (state_ff)
         FR_IDLE: begin
            req_ready = !full;
            if (req_valid && !full) begin
               if (op == OP_START && ch_ok && freq_ok) begin
                  div_req.start    = 1'b1;
                  div_req.dividend = DIVIDEND_W'(TICKS_PER_SECOND);
                  div_req.divisor  = {req_frequency_hz[FREQ_W-2:0], 1'b0};
                  cmd_in           = '0;
                  cmd_in.op        = OP_START;
                  cmd_in.channel   = req_channel;
                  freq_in          = req_frequency_hz;
                  dur_in           = req_duration_ms;
                  state_in         = FR_HALF;
               end else begin
                  push = 1'b1;
               end
            end
         end
         FR_HALF: begin
            prod_in = DIVIDEND_W'({freq_ff, 1'b0} * dur_ff);
            if (div_rsp.done) begin
               if (div_rsp.quotient > DIVIDEND_W'(HALF_MAX)) begin
                  cmd_in.half = HALF_MAX;
               end else if (div_rsp.quotient == '0) begin
                  cmd_in.half = HALF_W'(1);
               end else begin
                  cmd_in.half = div_rsp.quotient[HALF_W-1:0];
               end
               if (dur_ff == '0) begin
                  cmd_in.endless = 1'b1;
                  state_in       = FR_PUSH;
               end else begin
                  state_in       = FR_BUDGET;
               end
            end
         end
         FR_BUDGET: begin
            cmd_in.budget = scaled[RECIP_SHIFT +: BUDGET_W];
            state_in      = FR_PUSH;
         end
         FR_PUSH: begin
            push_data = cmd_ff;
            if (!full) begin
               push     = 1'b1;
               state_in = FR_IDLE;
            end
         end
         default: begin
            state_in = FR_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FR_IDLE;
      end else begin
         state_ff <= state_in;
      end
      cmd_ff  <= cmd_in;
      freq_ff <= freq_in;
      dur_ff  <= dur_in;
      prod_ff <= prod_in;
   end

`ifndef SYNTHESIS
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("front pushed into a full queue");
   a_start_half: assert property (@(posedge clock) disable iff (reset)
      (push && push_data.op == OP_START) |-> (push_data.half != '0))
      else $error("start command with zero half period");
`endif

endmodule

FILE: rtl/core/tg_queue.sv
// tg_queue: short command queue between the front and back parts
// depends on tg_pkg
module tg_queue (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  tg_pkg::cmd_type push_data,
   output logic            full,
   input  logic            pop,
   output logic            not_empty,
   output tg_pkg::cmd_type pop_data
);
   import tg_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type           entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   assign full      = count_ff == CNT_W'(QUEUE_DEPTH);
   assign not_empty = count_ff != '0;
   assign pop_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("queue count above depth");
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("pop from empty queue");
`endif

endmodule

FILE: rtl/core/tg_back.sv
// tg_back: runs queued commands against the shared counter and channel state
// depends on tg_pkg; drives the registered response beat
module tg_back #(
   parameter int CHANNELS = 8
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            not_empty,
   input  tg_pkg::cmd_type pop_data,
   output logic            pop,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output logic [7:0]      rsp_tone_levels,
   output logic [7:0]      rsp_active_mask,
   output logic [7:0]      rsp_finished_mask,
   output logic            rsp_accepted
);
   import tg_pkg::*;

   localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int SHOWN = (CHANNELS < MASK_W) ? CHANNELS : MASK_W;

   logic [COUNT_W-1:0]  counter_ff, counter_in;
   logic [HALF_W-1:0]   half_ff    [CHANNELS];
   logic [HALF_W-1:0]   half_in    [CHANNELS];
   logic [BUDGET_W-1:0] left_ff    [CHANNELS];
   logic [BUDGET_W-1:0] left_in    [CHANNELS];
   logic [COUNT_W-1:0]  cmp_ff     [CHANNELS];
   logic [COUNT_W-1:0]  cmp_in     [CHANNELS];
   logic                endless_ff [CHANNELS];
   logic                endless_in [CHANNELS];
   logic                level_ff   [CHANNELS];
   logic                level_in   [CHANNELS];

   logic                rsp_valid_ff, rsp_valid_in;
   logic [MASK_W-1:0]   levels_ff, levels_in;
   logic [MASK_W-1:0]   active_ff, active_in;
   logic [MASK_W-1:0]   finished_ff, finished_in;
   logic                accepted_ff, accepted_in;

   assign pop = not_empty && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      logic [CH_W-1:0]     idx;
      logic [CHANNELS-1:0] fin;
      idx        = CH_W'(pop_data.channel);
      fin        = '0;
      counter_in = counter_ff;
      half_in    = half_ff;
      left_in    = left_ff;
      cmp_in     = cmp_ff;
      endless_in = endless_ff;
      level_in   = level_ff;
      if (pop) begin
         case (pop_data.op)
            OP_TICK: begin
               counter_in = counter_ff + 1'b1;
               for (int i = 0; i < CHANNELS; i++) begin
                  if (half_ff[i] != '0 && cmp_ff[i] == counter_in) begin
                     level_in[i] = !level_ff[i];
                     cmp_in[i]   = cmp_ff[i] + {1'b0, half_ff[i]};
                     if (!endless_ff[i]) begin
                        if (left_ff[i] != '0) begin
                           left_in[i] = left_ff[i] - 1'b1;
                        end else begin
                           half_in[i]    = '0;
                           left_in[i]    = '0;
                           endless_in[i] = 1'b0;
                           cmp_in[i]     = '0;
                           level_in[i]   = 1'b0;
                           fin[i]        = 1'b1;
                        end
                     end
                  end
               end
            end
            OP_START: begin
               half_in[idx]    = pop_data.half;
               left_in[idx]    = pop_data.budget;
               endless_in[idx] = pop_data.endless;
               cmp_in[idx]     = counter_ff + {1'b0, pop_data.half};
               level_in[idx]   = 1'b0;
            end
            OP_STOP: begin
               half_in[idx]    = '0;
               left_in[idx]    = '0;
               endless_in[idx] = 1'b0;
               cmp_in[idx]     = '0;
               level_in[idx]   = 1'b0;
            end
            default: begin
            end
         endcase
      end
      rsp_valid_in = pop ? 1'b1 : (rsp_valid_ff && !rsp_ready);
      levels_in    = levels_ff;
      active_in    = active_ff;
      finished_in  = finished_ff;
      accepted_in  = accepted_ff;
      if (pop) begin
         levels_in   = '0;
         active_in   = '0;
         finished_in = '0;
         for (int i = 0; i < SHOWN; i++) begin
            levels_in[i]   = level_in[i];
            active_in[i]   = half_in[i] != '0;
            finished_in[i] = fin[i];
         end
         accepted_in = pop_data.op == OP_START;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         counter_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < CHANNELS; i++) begin
            half_ff[i]    <= '0;
            left_ff[i]    <= '0;
            cmp_ff[i]     <= '0;
            endless_ff[i] <= 1'b0;
            level_ff[i]   <= 1'b0;
         end
      end else begin
         counter_ff   <= counter_in;
         rsp_valid_ff <= rsp_valid_in;
         half_ff      <= half_in;
         left_ff      <= left_in;
         cmp_ff       <= cmp_in;
         endless_ff   <= endless_in;
         level_ff     <= level_in;
      end
      levels_ff   <= levels_in;
      active_ff   <= active_in;
      finished_ff <= finished_in;
      accepted_ff <= accepted_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_tone_levels   = levels_ff;
   assign rsp_active_mask   = active_ff;
   assign rsp_finished_mask = finished_ff;
   assign rsp_accepted      = accepted_ff;

`ifndef SYNTHESIS
   a_level_needs_active: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((levels_ff & ~active_ff) == '0))
      else $error("high level on a stopped channel");
   a_finished_stopped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((finished_ff & active_ff) == '0))
      else $error("finished channel still active");
   a_counter_tick: assert property (@(posedge clock) disable iff (reset)
      (pop && pop_data.op != OP_TICK) |=> $stable(counter_ff))
      else $error("counter moved on a non-tick beat");
`endif

endmodule

FILE: rtl/core/multichannel_tone_generator_top.sv
// multichannel_tone_generator_top: square-wave tone generator, shared 16-bit tick counter
// depends on tg_pkg, tg_front, tg_queue, tg_back
//
//   channel | direction | ports                                        | handshake
//   req     | in        | req_op req_channel req_frequency_hz          | req_valid/req_ready
//           |           | req_duration_ms                              |
//   rsp     | out       | rsp_tone_levels rsp_active_mask              | rsp_valid/rsp_ready
//           |           | rsp_finished_mask rsp_accepted               |
//
// tick, stop and no-op beats are taken one per cycle while the front is idle and the two-entry queue has room
// an in-range start occupies the front for one 32-step pass through the serial divider,
// then, unless its duration is zero, a reciprocal multiply for the budget
// each response comes in the cycle after its command leaves the queue, from a response register
// reset is synchronous and clears all channels and the counter
// a stalled rsp side fills the queue, then drops req_ready
module multichannel_tone_generator_top #(
   parameter int CHANNELS         = 8,
   parameter int TICKS_PER_SECOND = 1000000
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_op,
   input  logic [2:0]  req_channel,
   input  logic [15:0] req_frequency_hz,
   input  logic [15:0] req_duration_ms,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_tone_levels,
   output logic [7:0]  rsp_active_mask,
   output logic [7:0]  rsp_finished_mask,
   output logic        rsp_accepted
);
   import tg_pkg::*;

   logic    push;
   cmd_type push_data;
   logic    full;
   logic    pop;
   logic    not_empty;
   cmd_type pop_data;

   tg_front #(
      .CHANNELS         (CHANNELS),
      .TICKS_PER_SECOND (TICKS_PER_SECOND)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_op           (req_op),
      .req_channel      (req_channel),
      .req_frequency_hz (req_frequency_hz),
      .req_duration_ms  (req_duration_ms),
      .push             (push),
      .push_data        (push_data),
      .full             (full)
   );

   tg_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .pop       (pop),
      .not_empty (not_empty),
      .pop_data  (pop_data)
   );

   tg_back #(
      .CHANNELS (CHANNELS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .not_empty         (not_empty),
      .pop_data          (pop_data),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_tone_levels   (rsp_tone_levels),
      .rsp_active_mask   (rsp_active_mask),
      .rsp_finished_mask (rsp_finished_mask),
      .rsp_accepted      (rsp_accepted)
   );

endmodule
